/* hdl/mdle_pkg.sv */
package mdle_pkg;

	localparam int MaxSrc = 32;
	localparam int MaxDst = 32;
	localparam int FracBits = 12;
	localparam int SrcW = $clog2(MaxSrc);
	localparam int DstW = $clog2(MaxDst);
	localparam int AddrW = SrcW + DstW;
	localparam int Depth = MaxSrc * MaxDst;
	localparam int CntW = $clog2(Depth + 1);
	localparam int AccW = 48;
	localparam logic [15:0] Lth = 16'((6 << FracBits) / 10);

	typedef enum logic [2:0] {
		OP_WEIGHT = 3'd0,
		OP_ACT    = 3'd1,
		OP_EVAL   = 3'd2,
		OP_PRUNE  = 3'd3,
		OP_COUNT  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CFG_SRC   = 2'd0,
		CFG_DST   = 2'd1,
		CFG_PRUNE = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH,
		ST_OUT
	} state_t;

	function automatic logic [16:0] sig_tab(input logic [4:0] i);
		case (i)
			5'd0: sig_tab = 17'd32768;
			5'd1: sig_tab = 17'd40793;
			5'd2: sig_tab = 17'd47911;
			5'd3: sig_tab = 17'd53581;
			5'd4: sig_tab = 17'd57724;
			5'd5: sig_tab = 17'd60565;
			5'd6: sig_tab = 17'd62428;
			5'd7: sig_tab = 17'd63615;
			5'd8: sig_tab = 17'd64357;
			5'd9: sig_tab = 17'd64816;
			5'd10: sig_tab = 17'd65097;
			5'd11: sig_tab = 17'd65269;
			5'd12: sig_tab = 17'd65374;
			5'd13: sig_tab = 17'd65438;
			5'd14: sig_tab = 17'd65476;
			5'd15: sig_tab = 17'd65500;
			default: sig_tab = 17'd65514;
		endcase
	endfunction

	// sigmoid of magnitude t, Q0.16
	function automatic logic [16:0] sig_pos(input logic [17:0] t);
		logic [17:0] idx;
		logic [FracBits-2:0] fr;
		logic [16:0] a;
		logic [16:0] b;
		logic [33:0] p;
		idx = t >> (FracBits - 1);
		fr = t[FracBits-2:0];
		a = sig_tab(idx[4:0]);
		b = sig_tab(5'(idx[4:0] + 5'd1));
		p = 34'(b - a) * 34'(fr);
		if (idx >= 18'd16)
			sig_pos = sig_tab(5'd16);
		else
			sig_pos = 17'(a + 17'(p >> (FracBits - 1)));
	endfunction

	function automatic logic [15:0] q16_to_frac(input logic [16:0] v);
		logic [33:0] t;
		t = (34'(v) << FracBits) + 34'd32768;
		q16_to_frac = 16'(t >> 16);
	endfunction

endpackage

/* hdl/mdle_ram.sv */
module mdle_ram #(
	parameter int Width = 16,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* hdl/mdle_act.sv */
module mdle_act import mdle_pkg::*; (
	input  logic        clk,
	input  logic [15:0] x,
	input  logic        sigm,
	output logic [15:0] y
);
	logic        neg_s1;
	logic        sigm_s1;
	logic [16:0] s_s1;
	logic [16:0] t;
	logic [16:0] r;
	logic [15:0] m;

	assign t = x[15] ? 17'(-$signed({x[15], x})) : 17'(x);

	always_ff @(posedge clk) begin
		neg_s1 <= x[15];
		sigm_s1 <= sigm;
		s_s1 <= sig_pos(sigm ? {1'b0, t} : {t, 1'b0});
	end

	always_comb begin
		r = 17'd0;
		m = 16'd0;
		if (sigm_s1) begin
			r = neg_s1 ? 17'(17'h10000 - s_s1) : s_s1;
			y = q16_to_frac(r);
		end else begin
			m = q16_to_frac(17'({s_s1, 1'b0} - 18'h10000));
			y = neg_s1 ? 16'(-m) : m;
		end
	end
endmodule

/* hdl/masked_dense_layer_engine.sv */
// Dense layer engine. Ops are 0 write weight, 1 write activation, 2 evaluate, 3 prune,
// 4 count cleared masks. After reset a clearing pass sets every mask bit before the
// first word is taken. Evaluate, prune and count walk every in-use connection through
// the weight and mask memories at one per cycle, except that evaluate pauses after each
// destination until its output word is taken. Evaluate emits one word per destination,
// count one word.
module masked_dense_layer_engine import mdle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata, // op, src_index, dst_index, data_value
	input  logic [1:0]  s_axis_tuser, // output_layer, threshold_mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata, // out_index, out_value, masked_count
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	state_t state_q, state_d;
	logic [5:0] src_cnt_q, dst_cnt_q;
	logic [14:0] thr_q;
	logic [2:0] op_q;
	logic sigm_q, tmode_q;
	logic [SrcW:0] s_q;
	logic [DstW:0] d_q;
	logic [AddrW:0] clr_q;
	logic v_s1, v_s2;
	logic [AddrW-1:0] a_s1;
	logic [AddrW-1:0] a_s2;
	logic signed [31:0] prod_s2;
	logic sel_s2, prune_s2;
	logic signed [AccW-1:0] acc_q;
	logic [CntW-1:0] cnt_q;
	logic [15:0] q_q;
	logic [15:0] out_v_q;
	logic act_v_q;
	logic [15:0] act_y;

	logic [5:0] ns, nd;
	assign ns = (src_cnt_q > 6'(MaxSrc)) ? 6'(MaxSrc) : src_cnt_q;
	assign nd = (dst_cnt_q > 6'(MaxDst)) ? 6'(MaxDst) : dst_cnt_q;

	logic in_acc;
	logic [2:0] in_op;
	logic [SrcW-1:0] in_si;
	logic [DstW-1:0] in_di;
	logic [15:0] in_val;
	assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_op = s_axis_tdata[2:0];
	assign in_si = s_axis_tdata[7:3];
	assign in_di = s_axis_tdata[12:8];
	assign in_val = s_axis_tdata[28:13];

	logic walking;
	logic [AddrW-1:0] raddr;
	assign walking = (state_q == ST_WALK);
	assign raddr = {s_q[SrcW-1:0], d_q[DstW-1:0]};

	logic w_we, m_we, a_we;
	logic [AddrW-1:0] w_wa, m_wa;
	logic m_wd;
	logic [15:0] w_rd, a_rd;
	logic m_rd;

	assign w_we = in_acc && in_op == OP_WEIGHT;
	assign w_wa = {in_si, in_di};
	assign a_we = in_acc && in_op == OP_ACT;

	always_comb begin
		m_we = 1'b0;
		m_wa = w_wa;
		m_wd = 1'b1;
		if (state_q == ST_CLEAR) begin
			m_we = 1'b1;
			m_wa = clr_q[AddrW-1:0];
		end else if (w_we) begin
			m_we = 1'b1;
		end else if (v_s2 && prune_s2) begin
			m_we = 1'b1;
			m_wa = a_s2;
			m_wd = 1'b0;
		end
	end

	mdle_ram #(.Width(16), .Depth(Depth)) u_w (.clk, .we(w_we), .waddr(w_wa),
		.wdata(in_val), .raddr(raddr), .rdata(w_rd));
	mdle_ram #(.Width(1), .Depth(Depth)) u_m (.clk, .we(m_we), .waddr(m_wa),
		.wdata(m_wd), .raddr(raddr), .rdata(m_rd));
	mdle_ram #(.Width(16), .Depth(MaxSrc)) u_a (.clk, .we(a_we), .waddr(in_si),
		.wdata(in_val), .raddr(s_q[SrcW-1:0]), .rdata(a_rd));

	mdle_act u_act (.clk, .x(q_q), .sigm(sigm_q), .y(act_y));

	logic [15:0] aw;
	assign aw = w_rd[15] ? 16'(-w_rd) : w_rd;

	logic s_end;
	assign s_end = (6'(s_q) + 6'd1 >= ns);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == (AddrW+1)'(Depth - 1)) state_d = ST_IDLE;
			ST_IDLE: if (in_acc && (in_op == OP_EVAL || in_op == OP_PRUNE ||
				in_op == OP_COUNT)) begin
				if (nd == 6'd0 || (ns == 6'd0 && in_op != OP_EVAL))
					state_d = (in_op == OP_COUNT) ? ST_FINISH : ST_IDLE;
				else if (ns == 6'd0)
					state_d = ST_DRAIN;
				else
					state_d = ST_WALK;
			end
			ST_WALK: if (s_end && (op_q == OP_EVAL || 6'(d_q) + 6'd1 >= nd))
				state_d = ST_DRAIN;
			ST_DRAIN: if (!v_s1 && !v_s2) state_d = ST_FINISH;
			ST_FINISH: begin
				if (op_q == OP_PRUNE) state_d = ST_IDLE;
				else if (op_q == OP_COUNT) state_d = ST_OUT;
				else if (act_v_q) state_d = ST_OUT;
			end
			ST_OUT: if (m_axis_tready) begin
				if (op_q == OP_EVAL && 6'(d_q) + 6'd1 < nd)
					state_d = (ns == 6'd0) ? ST_DRAIN : ST_WALK;
				else
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tlast = (op_q == OP_COUNT) || (6'(d_q) + 6'd1 >= nd);
	assign m_axis_tdata = (op_q == OP_COUNT) ? {11'(cnt_q), 16'd0, 5'd0}
		: {11'd0, out_v_q, d_q[DstW-1:0]};

	logic signed [AccW-1:0] sh;
	assign sh = acc_q >>> FracBits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			src_cnt_q <= 6'd32;
			dst_cnt_q <= 6'd32;
			thr_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			act_v_q <= 1'b0;
			op_q <= OP_WEIGHT;
			s_q <= '0;
			d_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				case (cfg_index)
					CFG_SRC: src_cnt_q <= cfg_data[5:0];
					CFG_DST: dst_cnt_q <= cfg_data[5:0];
					CFG_PRUNE: thr_q <= cfg_data;
					default: ;
				endcase
			end
			v_s1 <= walking;
			v_s2 <= v_s1;
			act_v_q <= (state_q == ST_FINISH) && op_q == OP_EVAL && !act_v_q;
			if (in_acc) begin
				op_q <= in_op;
				s_q <= '0;
				d_q <= '0;
			end else if (walking) begin
				if (s_end) begin
					s_q <= '0;
					if (op_q != OP_EVAL) d_q <= d_q + 1'b1;
				end else
					s_q <= s_q + 1'b1;
			end else if (state_q == ST_OUT && m_axis_tready && op_q == OP_EVAL)
				d_q <= d_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= raddr;
		a_s2 <= a_s1;
		if (in_acc) begin
			sigm_q <= s_axis_tuser[0];
			tmode_q <= s_axis_tuser[1];
			acc_q <= '0;
			cnt_q <= '0;
		end
		prod_s2 <= $signed(w_rd) * $signed(a_rd);
		sel_s2 <= tmode_q ? (aw > Lth) : m_rd;
		prune_s2 <= (op_q == OP_PRUNE) && (aw <= {1'b0, thr_q});
		if (v_s1 && op_q == OP_COUNT && !m_rd) cnt_q <= cnt_q + 1'b1;
		if (v_s2 && op_q == OP_EVAL && sel_s2) acc_q <= acc_q + AccW'(prod_s2);
		if (state_q == ST_DRAIN && !v_s1 && !v_s2)
			q_q <= (sh > 48'sd32767) ? 16'h7fff : (sh < -48'sd32768) ? 16'h8000 : sh[15:0];
		if (act_v_q) out_v_q <= act_y;
		if (state_q == ST_OUT && m_axis_tready) acc_q <= '0;
	end
endmodule

/* hdl/mdle_checker.sv */
module mdle_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic m_axis_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while output pending");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("word after last");
endmodule

bind masked_dense_layer_engine mdle_checker u_chk (.clk, .arst_n,
	.s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast);
